// File: design/assert_macros.svh
// Assertion shorthands used by particle_pool_update; all use i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Types, codes and reset constants of the particle pool update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppu_pkg;

    localparam int PoolSizeDef = 64;
    localparam int CntW        = 7;
    localparam int DivW        = 48;

    localparam logic [31:0] PeriodRst   = 32'd655;
    localparam logic [31:0] LifeMinRst  = 32'd65536;
    localparam logic [31:0] LifeMaxRst  = 32'd131072;
    localparam logic [30:0] SpeedMinRst = 31'd65536;
    localparam logic [30:0] SpeedMaxRst = 31'd327680;
    localparam logic [31:0] SizePairRst = 32'd16777242;
    localparam logic [63:0] ColourRst   = 64'hFFFF_FFFF_0000_0000;
    localparam logic [6:0]  LimitRst    = 7'd64;
    localparam logic [31:0] RngSeed     = 32'h2545_F491;

    typedef enum logic [2:0] {
        CFG_PERIOD    = 3'd0,
        CFG_LIFE_MIN  = 3'd1,
        CFG_LIFE_MAX  = 3'd2,
        CFG_SPEED_MIN = 3'd3,
        CFG_SPEED_MAX = 3'd4,
        CFG_SIZE      = 3'd5,
        CFG_COLOUR    = 3'd6,
        CFG_LIMIT     = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        LANE_SIZE  = 3'd0,
        LANE_RED   = 3'd1,
        LANE_GREEN = 3'd2,
        LANE_BLUE  = 3'd3,
        LANE_ALPHA = 3'd4
    } t_lane;

    typedef enum logic [4:0] {
        S_IDLE, S_TCHK, S_TDIV, S_TSET,
        S_LIFE, S_SPEED, S_C0, S_C1, S_C2, S_SUM, S_SQRT,
        S_VMUL, S_VDGO, S_VDIV, S_VSET, S_WRITE,
        S_URD, S_UAGE, S_UCOPY, S_MX, S_MY, S_MZ,
        S_ORD, S_OFRAC, S_FDIV, S_FSET, S_LERP, S_LACC, S_EMIT
    } t_state;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [31:0]        age;
        logic [31:0]        life;
    } t_rec;

endpackage

`default_nettype wire

// File: design/particle_pool_update.sv
// ----------------------------------------------------------------------------
// particle_pool_update
// Emitter and particle pool: spawn, age, move, swap-remove, shade, in Q16.16.
// ----------------------------------------------------------------------------
// channel  | handshake              | payload
// tick     | start / busy           | i_dt
// config   | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
// result   | o_valid strobe         | o_pos_*, o_size, o_red..o_alpha, o_alive, o_last
//
// A tick checks the timer against the period, spawns into the free room, ages,
// moves or swap-removes each live particle and emits one result per live one;
// the 48-step shared divider and the 17-step root loop take most of its time.
// busy stays high for the whole tick.
// Synchronous active-low reset; the pool store has no clearing pass.
// Results cannot be stalled; each strobe lasts one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module particle_pool_update #(
    parameter int POOL_SIZE = ppu_pkg::PoolSizeDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_dt,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic [15:0]        o_size,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [7:0]         o_alpha,
    output logic [6:0]         o_alive,
    output logic               o_last
);
    import ppu_pkg::*;

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [CntW-1:0] PoolCnt = CntW'(POOL_SIZE);

    function automatic logic signed [31:0] mv(input logic signed [31:0] p,
                                              input logic signed [65:0] pr);
        logic signed [65:0] adj;
        logic signed [65:0] sh;
        logic signed [33:0] s;
        adj = pr + (pr[65] ? 66'sd65535 : 66'sd0);
        sh  = adj >>> 16;
        s   = $signed({{2{p[31]}}, p}) + $signed(sh[33:0]);
        if (!s[33] && (s[32] || s[31])) begin
            return 32'sh7FFF_FFFF;
        end else if (s[33] && !(s[32] && s[31])) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    t_state r_state, n_state;

    logic [31:0] r_period, n_period, r_life_min, n_life_min, r_life_max, n_life_max;
    logic [30:0] r_speed_min, n_speed_min, r_speed_max, n_speed_max;
    logic [31:0] r_size_pair, n_size_pair;
    logic [63:0] r_colour, n_colour;
    logic [6:0]  r_limit, n_limit;

    logic [6:0]  r_live, n_live;
    logic [31:0] r_timer, n_timer, r_rng, n_rng;
    logic [5:0]  r_dcnt, n_dcnt;
    logic        r_o_valid, n_o_valid;

    logic [15:0]        r_dt, n_dt;
    logic [31:0]        r_t, n_t;
    logic [6:0]         r_spawn, n_spawn, r_i, n_i;
    logic [31:0]        r_life, n_life;
    logic [30:0]        r_speed, n_speed;
    logic signed [17:0] r_c [3];
    logic signed [17:0] n_c [3];
    logic [1:0]         r_k, n_k;
    logic [33:0]        r_sum, n_sum;
    logic [34:0]        r_sqv, n_sqv, r_sqr, n_sqr;
    logic [4:0]         r_sqk, n_sqk;
    logic               r_neg, n_neg;
    logic signed [31:0] r_vel [3];
    logic signed [31:0] n_vel [3];
    t_rec               r_rec, n_rec;
    logic [15:0]        r_f, n_f;
    t_lane              r_lk, n_lk;
    logic [15:0]        r_lerp [5];
    logic [15:0]        n_lerp [5];
    logic signed [65:0] r_prod;
    logic [DivW-1:0]    r_dq, n_dq;
    logic [32:0]        r_drem, n_drem;
    logic [31:0]        r_ddiv, n_ddiv;

    logic signed [31:0] r_o_px, r_o_py, r_o_pz;
    logic [15:0]        r_o_size;
    logic [7:0]         r_o_red, r_o_green, r_o_blue, r_o_alpha;
    logic [6:0]         r_o_alive;
    logic               r_o_last;

    t_rec            mem [POOL_SIZE];
    t_rec            r_rd;
    logic            mem_we;
    logic [AW-1:0]   mem_wa, mem_ra;
    t_rec            mem_wd;

    logic [31:0]        x1, x2, rng_x;
    logic [15:0]        u;
    logic [31:0]        p_eff;
    logic [6:0]         limit_eff, room, live_m1;
    logic [32:0]        t_sum, age_sum;
    logic [31:0]        age_n;
    logic               expired;
    logic signed [65:0] prod_hi, prod_abs;
    logic signed [17:0] c_new;
    logic signed [32:0] mul_a, mul_b;
    logic [32:0]        rem2;
    logic               ge;
    logic [34:0]        bitv, trial;
    logic [33:0]        sum_full;
    logic [15:0]        lane_a, lane_b;
    logic signed [16:0] lane_d;
    logic               div_load;
    logic [DivW-1:0]    div_a;
    logic [31:0]        div_b;
    logic [31:0]        qv;

    assign x1        = r_rng ^ (r_rng << 13);
    assign x2        = x1 ^ (x1 >> 17);
    assign rng_x     = x2 ^ (x2 << 5);
    assign u         = rng_x[31:16];
    assign p_eff     = (r_period == 32'd0) ? 32'd1 : r_period;
    assign limit_eff = (r_limit > PoolCnt) ? PoolCnt : r_limit;
    assign room      = (limit_eff > r_live) ? limit_eff - r_live : 7'd0;
    assign live_m1   = r_live - 7'd1;
    assign t_sum     = {1'b0, r_timer} + {17'd0, i_dt};
    assign age_sum   = {1'b0, r_rd.age} + {17'd0, r_dt};
    assign age_n     = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    assign expired   = age_n >= r_rd.life;
    assign prod_hi   = r_prod >>> 16;
    assign prod_abs  = r_prod[65] ? -r_prod : r_prod;
    assign c_new     = $signed({1'b0, u, 1'b0}) - 18'sd65536;
    assign rem2      = {r_drem[31:0], r_dq[DivW-1]};
    assign ge        = rem2 >= {1'b0, r_ddiv};
    assign bitv      = 35'd1 << {r_sqk, 1'b0};
    assign trial     = r_sqr + bitv;
    assign sum_full  = r_sum + r_prod[33:0];
    assign lane_d    = $signed({1'b0, lane_b}) - $signed({1'b0, lane_a});
    assign qv        = r_dq[31:0];

    always_comb begin
        unique case (r_lk)
            LANE_SIZE: begin
                lane_a = r_size_pair[31:16];
                lane_b = r_size_pair[15:0];
            end
            LANE_RED: begin
                lane_a = {8'd0, r_colour[63:56]};
                lane_b = {8'd0, r_colour[31:24]};
            end
            LANE_GREEN: begin
                lane_a = {8'd0, r_colour[55:48]};
                lane_b = {8'd0, r_colour[23:16]};
            end
            LANE_BLUE: begin
                lane_a = {8'd0, r_colour[47:40]};
                lane_b = {8'd0, r_colour[15:8]};
            end
            LANE_ALPHA: begin
                lane_a = {8'd0, r_colour[39:32]};
                lane_b = {8'd0, r_colour[7:0]};
            end
            default: begin
                lane_a = 16'd0;
                lane_b = 16'd0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_TCHK;
            S_TCHK:  n_state = (r_t > p_eff) ? S_TDIV : S_URD;
            S_TDIV:  if (r_dcnt == 6'd0) n_state = S_TSET;
            S_TSET:  n_state = ((r_dq >= DivW'(room)) ? (room == 7'd0)
                                : (r_dq[6:0] == 7'd0)) ? S_URD : S_LIFE;
            S_LIFE:  n_state = S_SPEED;
            S_SPEED: n_state = S_C0;
            S_C0:    n_state = S_C1;
            S_C1:    n_state = S_C2;
            S_C2:    n_state = S_SUM;
            S_SUM:   n_state = S_SQRT;
            S_SQRT:  if (r_sqk == 5'd0) n_state = S_VMUL;
            S_VMUL:  n_state = S_VDGO;
            S_VDGO:  n_state = S_VDIV;
            S_VDIV:  if (r_dcnt == 6'd0) n_state = S_VSET;
            S_VSET:  n_state = (r_k == 2'd2) ? S_WRITE : S_VMUL;
            S_WRITE: n_state = (r_spawn == 7'd1) ? S_URD : S_LIFE;
            S_URD:   n_state = (r_i < r_live) ? S_UAGE : S_ORD;
            S_UAGE: begin
                if (!expired) begin
                    n_state = S_MX;
                end else begin
                    n_state = (r_i == live_m1) ? S_URD : S_UCOPY;
                end
            end
            S_UCOPY: n_state = S_URD;
            S_MX:    n_state = S_MY;
            S_MY:    n_state = S_MZ;
            S_MZ:    n_state = S_URD;
            S_ORD:   n_state = (r_i < r_live) ? S_OFRAC : S_IDLE;
            S_OFRAC: n_state = S_FDIV;
            S_FDIV:  if (r_dcnt == 6'd0) n_state = S_FSET;
            S_FSET:  n_state = S_LERP;
            S_LERP:  n_state = S_LACC;
            S_LACC:  n_state = (r_lk == LANE_ALPHA) ? S_EMIT : S_LERP;
            S_EMIT:  n_state = S_ORD;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_period = r_period; n_life_min = r_life_min; n_life_max = r_life_max;
        n_speed_min = r_speed_min; n_speed_max = r_speed_max;
        n_size_pair = r_size_pair; n_colour = r_colour; n_limit = r_limit;
        n_live = r_live; n_timer = r_timer; n_rng = r_rng;
        n_o_valid = 1'b0;
        n_dt = r_dt; n_t = r_t; n_spawn = r_spawn; n_i = r_i;
        n_life = r_life; n_speed = r_speed; n_c = r_c; n_k = r_k; n_sum = r_sum;
        n_sqv = r_sqv; n_sqr = r_sqr; n_sqk = r_sqk; n_neg = r_neg; n_vel = r_vel;
        n_rec = r_rec; n_f = r_f; n_lk = r_lk; n_lerp = r_lerp;
        mul_a = 33'sd0; mul_b = 33'sd0;
        div_load = 1'b0; div_a = '0; div_b = 32'd0;
        mem_we = 1'b0; mem_wa = r_i[AW-1:0]; mem_ra = r_i[AW-1:0];
        mem_wd = r_rec;

        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD:    n_period    = i_cfg_data[31:0];
                CFG_LIFE_MIN:  n_life_min  = i_cfg_data[31:0];
                CFG_LIFE_MAX:  n_life_max  = i_cfg_data[31:0];
                CFG_SPEED_MIN: n_speed_min = i_cfg_data[30:0];
                CFG_SPEED_MAX: n_speed_max = i_cfg_data[30:0];
                CFG_SIZE:      n_size_pair = i_cfg_data[31:0];
                CFG_COLOUR:    n_colour    = i_cfg_data;
                CFG_LIMIT:     n_limit     = i_cfg_data[6:0];
                default:       n_limit     = r_limit;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                n_dt = i_dt;
                n_t  = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
            end
            S_TCHK: begin
                n_i = 7'd0;
                if (r_t > p_eff) begin
                    div_load = 1'b1;
                    div_a    = DivW'(r_t - 32'd1);
                    div_b    = p_eff;
                end else begin
                    n_timer = r_t;
                end
            end
            S_TSET: begin
                n_i     = 7'd0;
                n_timer = r_drem[31:0] + 32'd1;
                n_spawn = (r_dq >= DivW'(room)) ? room : r_dq[6:0];
            end
            S_LIFE: begin
                n_rng = rng_x;
                mul_a = $signed({1'b0, r_life_max}) - $signed({1'b0, r_life_min});
                mul_b = $signed({17'd0, u});
            end
            S_SPEED: begin
                n_life = r_life_min + prod_hi[31:0];
                n_rng  = rng_x;
                mul_a  = $signed({2'b0, r_speed_max}) - $signed({2'b0, r_speed_min});
                mul_b  = $signed({17'd0, u});
            end
            S_C0, S_C1, S_C2: begin
                if (r_state == S_C0) begin
                    n_speed = r_speed_min + prod_hi[30:0];
                    n_c[0]  = c_new;
                end else if (r_state == S_C1) begin
                    n_sum  = r_prod[33:0];
                    n_c[1] = c_new;
                end else begin
                    n_sum  = sum_full;
                    n_c[2] = c_new;
                end
                n_rng = rng_x;
                mul_a = 33'(c_new);
                mul_b = 33'(c_new);
            end
            S_SUM: begin
                n_sqv = {1'b0, sum_full};
                n_sqr = 35'd0;
                n_sqk = 5'd16;
                n_k   = 2'd0;
            end
            S_SQRT: begin
                if (r_sqv >= trial) begin
                    n_sqv = r_sqv - trial;
                    n_sqr = (r_sqr >> 1) + bitv;
                end else begin
                    n_sqr = r_sqr >> 1;
                end
                if (r_sqk != 5'd0) n_sqk = r_sqk - 5'd1;
            end
            S_VMUL: begin
                mul_a = 33'(r_c[r_k]);
                mul_b = $signed({2'b0, r_speed});
            end
            S_VDGO: begin
                n_neg    = r_prod[65];
                div_load = 1'b1;
                div_a    = prod_abs[DivW-1:0];
                div_b    = r_sqr[31:0];
            end
            S_VSET: begin
                n_vel[r_k] = (r_sqr == 35'd0) ? 32'sd0 : (r_neg ? -$signed(qv) : $signed(qv));
                n_k = r_k + 2'd1;
            end
            S_WRITE: begin
                mem_we  = 1'b1;
                mem_wa  = r_live[AW-1:0];
                mem_wd  = '{px: 32'sd0, py: 32'sd0, pz: 32'sd0, vx: r_vel[0],
                            vy: r_vel[1], vz: r_vel[2], age: 32'd0, life: r_life};
                n_live  = r_live + 7'd1;
                n_spawn = r_spawn - 7'd1;
                n_i     = 7'd0;
            end
            S_URD: begin
                if (!(r_i < r_live)) n_i = 7'd0;
            end
            S_UAGE: begin
                n_rec     = r_rd;
                n_rec.age = age_n;
                mem_ra    = live_m1[AW-1:0];
                if (expired && r_i == live_m1) n_live = live_m1;
                mul_a = 33'(r_rd.vx);
                mul_b = $signed({17'd0, r_dt});
            end
            S_UCOPY: begin
                mem_we = 1'b1;
                mem_wd = r_rd;
                n_live = live_m1;
            end
            S_MX: begin
                n_rec.px = mv(r_rec.px, r_prod);
                mul_a = 33'(r_rec.vy);
                mul_b = $signed({17'd0, r_dt});
            end
            S_MY: begin
                n_rec.py = mv(r_rec.py, r_prod);
                mul_a = 33'(r_rec.vz);
                mul_b = $signed({17'd0, r_dt});
            end
            S_MZ: begin
                mem_we    = 1'b1;
                mem_wd    = r_rec;
                mem_wd.pz = mv(r_rec.pz, r_prod);
                n_i       = r_i + 7'd1;
            end
            S_OFRAC: begin
                n_rec    = r_rd;
                div_load = 1'b1;
                div_a    = {r_rd.age, 16'd0};
                div_b    = r_rd.life;
            end
            S_FSET: begin
                if (r_rec.life == 32'd0) begin
                    n_f = 16'd0;
                end else begin
                    n_f = (|r_dq[DivW-1:16]) ? 16'hFFFF : r_dq[15:0];
                end
                n_lk = LANE_SIZE;
            end
            S_LERP: begin
                mul_a = 33'(lane_d);
                mul_b = $signed({17'd0, r_f});
            end
            S_LACC: begin
                n_lerp[r_lk] = lane_a + prod_hi[15:0];
                n_lk = t_lane'(r_lk + 3'd1);
            end
            S_EMIT: begin
                n_o_valid = 1'b1;
                n_i       = r_i + 7'd1;
            end
            default: n_o_valid = 1'b0;
        endcase

        if (div_load) begin
            n_dq   = div_a;
            n_drem = 33'd0;
            n_ddiv = div_b;
            n_dcnt = 6'(DivW);
        end else if (r_dcnt != 6'd0) begin
            n_dq   = {r_dq[DivW-2:0], ge};
            n_drem = ge ? rem2 - {1'b0, r_ddiv} : rem2;
            n_ddiv = r_ddiv;
            n_dcnt = r_dcnt - 6'd1;
        end else begin
            n_dq   = r_dq;
            n_drem = r_drem;
            n_ddiv = r_ddiv;
            n_dcnt = r_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PeriodRst;
            r_life_min  <= LifeMinRst;
            r_life_max  <= LifeMaxRst;
            r_speed_min <= SpeedMinRst;
            r_speed_max <= SpeedMaxRst;
            r_size_pair <= SizePairRst;
            r_colour    <= ColourRst;
            r_limit     <= LimitRst;
            r_live      <= 7'd0;
            r_timer     <= 32'd0;
            r_rng       <= RngSeed;
            r_dcnt      <= 6'd0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_period    <= n_period;
            r_life_min  <= n_life_min;
            r_life_max  <= n_life_max;
            r_speed_min <= n_speed_min;
            r_speed_max <= n_speed_max;
            r_size_pair <= n_size_pair;
            r_colour    <= n_colour;
            r_limit     <= n_limit;
            r_live      <= n_live;
            r_timer     <= n_timer;
            r_rng       <= n_rng;
            r_dcnt      <= n_dcnt;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dt    <= n_dt;
        r_t     <= n_t;
        r_spawn <= n_spawn;
        r_i     <= n_i;
        r_life  <= n_life;
        r_speed <= n_speed;
        r_c     <= n_c;
        r_k     <= n_k;
        r_sum   <= n_sum;
        r_sqv   <= n_sqv;
        r_sqr   <= n_sqr;
        r_sqk   <= n_sqk;
        r_neg   <= n_neg;
        r_vel   <= n_vel;
        r_rec   <= n_rec;
        r_f     <= n_f;
        r_lk    <= n_lk;
        r_lerp  <= n_lerp;
        r_prod  <= 66'(mul_a) * 66'(mul_b);
        r_dq    <= n_dq;
        r_drem  <= n_drem;
        r_ddiv  <= n_ddiv;
        if (r_state == S_EMIT) begin
            r_o_px    <= r_rec.px;
            r_o_py    <= r_rec.py;
            r_o_pz    <= r_rec.pz;
            r_o_size  <= r_lerp[0];
            r_o_red   <= r_lerp[1][7:0];
            r_o_green <= r_lerp[2][7:0];
            r_o_blue  <= r_lerp[3][7:0];
            r_o_alpha <= r_lerp[4][7:0];
            r_o_alive <= r_live;
            r_o_last  <= (r_i + 7'd1) == r_live;
        end
    end

    // pool store
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    assign busy        = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_pos_x     = r_o_px;
    assign o_pos_y     = r_o_py;
    assign o_pos_z     = r_o_pz;
    assign o_size      = r_o_size;
    assign o_red       = r_o_red;
    assign o_green     = r_o_green;
    assign o_blue      = r_o_blue;
    assign o_alpha     = r_o_alpha;
    assign o_alive     = r_o_alive;
    assign o_last      = r_o_last;

    `AST_IMP(a_live_cap, 1'b1, r_live <= PoolCnt, "live count above pool size")
    `AST_NXT(a_start_busy, start && !busy, busy, "request accepted but block not busy")
    `AST_IMP(a_div_wait, r_dcnt != 6'd0,
        r_state == S_TDIV || r_state == S_VDIV || r_state == S_FDIV,
        "divider running outside a wait state")
    `AST_IMP(a_out_alive, o_valid, o_alive != 7'd0, "result with empty pool")

endmodule

`default_nettype wire
